// ----- design/lr_pkg.sv -----
`timescale 1ns / 1ps
package lr_pkg;

    localparam int LR_COORD_BITS     = 6;
    localparam int LR_COLOR_BITS     = 32;
    localparam int LR_CFG_INDEX_BITS = 2;
    localparam int LR_FIFO_DEPTH     = 2;

    localparam logic [LR_CFG_INDEX_BITS-1:0] LR_REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [LR_CFG_INDEX_BITS-1:0] LR_REG_SCREEN_HEIGHT = 2'd1;

    typedef enum logic {
        LR_BACK_IDLE,
        LR_BACK_WALK
    } lr_back_state_t;

endpackage

// ----- design/lr_front.sv -----
`timescale 1ns / 1ps
module lr_front #(
    parameter int COORD_BITS = lr_pkg::LR_COORD_BITS,
    parameter int COLOR_BITS = lr_pkg::LR_COLOR_BITS,
    parameter int CMD_BITS   = 2 + 4 * COORD_BITS + COLOR_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    input  logic [COLOR_BITS-1:0] s_line_color,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output logic [CMD_BITS-1:0]   cmd_data
);

    logic                  hold_valid_reg;
    logic                  hold_valid_next;
    logic [CMD_BITS-1:0]   hold_data_reg;
    logic [CMD_BITS-1:0]   hold_data_next;
    logic                  rejected;
    logic                  steep;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;
    logic                  accept;

    // classify the line: backwards, steep, deltas
    always_comb begin
        rejected = (s_end_x < s_start_x) || (s_end_y < s_start_y);
        dx       = s_end_x - s_start_x;
        dy       = s_end_y - s_start_y;
        steep    = dy > dx;
        major    = steep ? dy : dx;
        minor    = steep ? dx : dy;
    end

    assign s_ready   = !hold_valid_reg || cmd_ready;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd_data  = hold_data_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
            hold_data_next  = {rejected, steep, major, minor, s_start_x, s_start_y,
                               s_line_color};
        end else if (cmd_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_data_reg <= hold_data_next;
    end

endmodule

// ----- design/lr_fifo.sv -----
`timescale 1ns / 1ps
module lr_fifo #(
    parameter int DATA_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  logic [DATA_BITS-1:0] wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH      = lr_pkg::LR_FIFO_DEPTH;
    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);
    localparam logic [PTR_BITS-1:0]   LAST_PTR   = PTR_BITS'(DEPTH - 1);

    logic [DATA_BITS-1:0]  slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  push;
    logic                  pop;

    assign wr_ready = count_reg != FULL_COUNT;
    assign rd_valid = count_reg != '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/lr_back.sv -----
`timescale 1ns / 1ps
module lr_back #(
    parameter int COORD_BITS = lr_pkg::LR_COORD_BITS,
    parameter int COLOR_BITS = lr_pkg::LR_COLOR_BITS,
    parameter int CMD_BITS   = 2 + 4 * COORD_BITS + COLOR_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [COORD_BITS:0]   screen_width,
    input  logic [COORD_BITS:0]   screen_height,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [CMD_BITS-1:0]   cmd_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [COLOR_BITS-1:0] m_pixel_color,
    output logic                  m_inside_screen,
    output logic                  m_line_rejected,
    output logic                  m_last_pixel
);

    localparam int ERR_BITS = COORD_BITS + 3;

    lr_pkg::lr_back_state_t state_reg;
    lr_pkg::lr_back_state_t state_next;

    logic                       rej_reg,    rej_next;
    logic                       steep_reg,  steep_next;
    logic [COORD_BITS-1:0]      major_reg,  major_next;
    logic [COORD_BITS-1:0]      minor_reg,  minor_next;
    logic [COORD_BITS-1:0]      walk_x_reg, walk_x_next;
    logic [COORD_BITS-1:0]      walk_y_reg, walk_y_next;
    logic signed [ERR_BITS-1:0] err_reg,    err_next;
    logic [COORD_BITS:0]        steps_reg,  steps_next;
    logic [COLOR_BITS-1:0]      color_reg,  color_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg,     out_x_next;
    logic [COORD_BITS-1:0] out_y_reg,     out_y_next;
    logic [COLOR_BITS-1:0] out_color_reg, out_color_next;
    logic                  out_inside_reg, out_inside_next;
    logic                  out_rej_reg,   out_rej_next;
    logic                  out_last_reg,  out_last_next;

    logic                       c_rej;
    logic                       c_steep;
    logic [COORD_BITS-1:0]      c_major;
    logic [COORD_BITS-1:0]      c_minor;
    logic [COORD_BITS-1:0]      c_sx;
    logic [COORD_BITS-1:0]      c_sy;
    logic [COLOR_BITS-1:0]      c_color;
    logic                       out_free;
    logic                       is_last;
    logic signed [ERR_BITS-1:0] err_sum;
    logic [COORD_BITS-1:0]      x_step;
    logic [COORD_BITS-1:0]      y_step;

    assign {c_rej, c_steep, c_major, c_minor, c_sx, c_sy, c_color} = cmd_data;

    assign out_free  = !out_valid_reg || m_ready;
    assign cmd_ready = state_reg == lr_pkg::LR_BACK_IDLE;

    assign m_valid         = out_valid_reg;
    assign m_pixel_x       = out_x_reg;
    assign m_pixel_y       = out_y_reg;
    assign m_pixel_color   = out_color_reg;
    assign m_inside_screen = out_inside_reg;
    assign m_line_rejected = out_rej_reg;
    assign m_last_pixel    = out_last_reg;

    always_comb begin
        state_next      = state_reg;
        rej_next        = rej_reg;
        steep_next      = steep_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;
        walk_x_next     = walk_x_reg;
        walk_y_next     = walk_y_reg;
        err_next        = err_reg;
        steps_next      = steps_reg;
        color_next      = color_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_color_next  = out_color_reg;
        out_inside_next = out_inside_reg;
        out_rej_next    = out_rej_reg;
        out_last_next   = out_last_reg;

        is_last = steps_reg == (COORD_BITS + 1)'(1);
        err_sum = err_reg + $signed({2'b00, minor_reg, 1'b0});
        x_step  = walk_x_reg;
        y_step  = walk_y_reg;

        // major axis always steps, minor axis on error reaching major delta
        if (err_sum >= $signed({3'b000, major_reg})) begin
            x_step = walk_x_reg + 1'b1;
            y_step = walk_y_reg + 1'b1;
        end
        if (steep_reg) begin
            y_step = walk_y_reg + 1'b1;
        end else begin
            x_step = walk_x_reg + 1'b1;
        end

        unique case (state_reg)
            lr_pkg::LR_BACK_IDLE: begin
                if (cmd_valid) begin
                    state_next  = lr_pkg::LR_BACK_WALK;
                    rej_next    = c_rej;
                    steep_next  = c_steep;
                    major_next  = c_major;
                    minor_next  = c_minor;
                    walk_x_next = c_sx;
                    walk_y_next = c_sy;
                    err_next    = '0;
                    steps_next  = c_rej ? (COORD_BITS + 1)'(1)
                                        : {1'b0, c_major} + 1'b1;
                    color_next  = c_color;
                end
            end
            lr_pkg::LR_BACK_WALK: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_rej_next    = rej_reg;
                    out_last_next   = is_last;
                    out_x_next      = rej_reg ? '0 : walk_x_reg;
                    out_y_next      = rej_reg ? '0 : walk_y_reg;
                    out_color_next  = rej_reg ? '0 : color_reg;
                    out_inside_next = !rej_reg
                                      && ({1'b0, walk_x_reg} < screen_width)
                                      && ({1'b0, walk_y_reg} < screen_height);
                    steps_next      = steps_reg - 1'b1;
                    if (is_last) begin
                        state_next = lr_pkg::LR_BACK_IDLE;
                    end else begin
                        walk_x_next = x_step;
                        walk_y_next = y_step;
                        if (err_sum >= $signed({3'b000, major_reg})) begin
                            err_next = err_sum - $signed({2'b00, major_reg, 1'b0});
                        end else begin
                            err_next = err_sum;
                        end
                    end
                end
            end
            default: begin
                state_next = lr_pkg::LR_BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lr_pkg::LR_BACK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rej_reg        <= rej_next;
        steep_reg      <= steep_next;
        major_reg      <= major_next;
        minor_reg      <= minor_next;
        walk_x_reg     <= walk_x_next;
        walk_y_reg     <= walk_y_next;
        err_reg        <= err_next;
        steps_reg      <= steps_next;
        color_reg      <= color_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_color_reg  <= out_color_next;
        out_inside_reg <= out_inside_next;
        out_rej_reg    <= out_rej_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ----- design/line_rasterizer.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake            | payload
// s_       | in        | s_valid / s_ready    | start_x, start_y, end_x, end_y, line_color
// m_       | out       | m_valid / m_ready    | pixel_x, pixel_y, pixel_color, inside_screen,
//          |           |                      | line_rejected, last_pixel
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// one pixel per cycle from the stepper unless the output stalls; a line of major delta d
// gives d + 1 pixels, a backwards line one pixel; the stepper loads a command while idle
// a line command is classified and registered, then queued two deep ahead of the stepper
// synchronous active-low reset clears all handshake state and sets both screen sizes
// to 2^COORD_BITS; output stall holds the stepper, a full queue holds s_ready low
module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::LR_COORD_BITS,
    parameter int COLOR_BITS = lr_pkg::LR_COLOR_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lr_pkg::LR_CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS:0]                  cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [COORD_BITS-1:0]                s_start_x,
    input  logic [COORD_BITS-1:0]                s_start_y,
    input  logic [COORD_BITS-1:0]                s_end_x,
    input  logic [COORD_BITS-1:0]                s_end_y,
    input  logic [COLOR_BITS-1:0]                s_line_color,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [COORD_BITS-1:0]                m_pixel_x,
    output logic [COORD_BITS-1:0]                m_pixel_y,
    output logic [COLOR_BITS-1:0]                m_pixel_color,
    output logic                                 m_inside_screen,
    output logic                                 m_line_rejected,
    output logic                                 m_last_pixel
);

    localparam int CMD_BITS = 2 + 4 * COORD_BITS + COLOR_BITS;
    localparam logic [COORD_BITS:0] SCREEN_RESET = (COORD_BITS + 1)'(1) << COORD_BITS;

    logic [COORD_BITS:0] screen_width_reg;
    logic [COORD_BITS:0] screen_width_next;
    logic [COORD_BITS:0] screen_height_reg;
    logic [COORD_BITS:0] screen_height_next;

    logic                front_valid;
    logic                front_ready;
    logic [CMD_BITS-1:0] front_data;
    logic                queue_valid;
    logic                queue_ready;
    logic [CMD_BITS-1:0] queue_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        if (cfg_valid) begin
            if (cfg_index == lr_pkg::LR_REG_SCREEN_WIDTH) begin
                screen_width_next = cfg_data;
            end else if (cfg_index == lr_pkg::LR_REG_SCREEN_HEIGHT) begin
                screen_height_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_RESET;
            screen_height_reg <= SCREEN_RESET;
        end else begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
        end
    end

    lr_front #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS),
        .CMD_BITS   (CMD_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_line_color (s_line_color),
        .cmd_valid    (front_valid),
        .cmd_ready    (front_ready),
        .cmd_data     (front_data)
    );

    lr_fifo #(
        .DATA_BITS (CMD_BITS)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_data),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_data  (queue_data)
    );

    lr_back #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS),
        .CMD_BITS   (CMD_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .screen_width    (screen_width_reg),
        .screen_height   (screen_height_reg),
        .cmd_valid       (queue_valid),
        .cmd_ready       (queue_ready),
        .cmd_data        (queue_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_pixel_color   (m_pixel_color),
        .m_inside_screen (m_inside_screen),
        .m_line_rejected (m_line_rejected),
        .m_last_pixel    (m_last_pixel)
    );

endmodule
